@@ src/sorted_table_linear_interp_macros.svh @@
// ---------------------------------------------------------------------------
// Assertion macros for the piecewise-linear table interpolator
// Shared helpers that tie every check to the block clock and reset.
// ---------------------------------------------------------------------------
`ifndef SORTED_TABLE_LINEAR_INTERP_MACROS_SVH
`define SORTED_TABLE_LINEAR_INTERP_MACROS_SVH

// A property that must hold at every clock edge outside reset.
`define STLI_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// A condition that must never be true outside reset.
`define STLI_ASSERT_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

@@ src/stli_pkg.sv @@
// ---------------------------------------------------------------------------
// Package for the piecewise-linear table interpolator
// Beat types, configuration bundle, status codes and sizing constants.
// ---------------------------------------------------------------------------
package stli_pkg;

  // Table sizing.
  localparam int TableDepth = 64;
  localparam int AddrW      = 6;
  localparam int CountW     = 7;

  // Input actions.
  localparam logic ActLoad  = 1'b0;
  localparam logic ActQuery = 1'b1;

  // Result status codes.
  localparam logic [1:0] StatusOk  = 2'd0;
  localparam logic [1:0] StatusFew = 2'd1;
  localparam logic [1:0] StatusSat = 2'd2;

  // Configuration register indexes.
  localparam logic [1:0] RegPointCount = 2'd0;
  localparam logic [1:0] RegExtLow     = 2'd1;
  localparam logic [1:0] RegExtHigh    = 2'd2;

  typedef struct packed {
    logic                action;
    logic [AddrW-1:0]    entry_index;
    logic signed [31:0]  point_x;
    logic signed [31:0]  point_y;
    logic signed [31:0]  query_x;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] result_y;
    logic [1:0]         status;
  } out_item_t;

  typedef struct packed {
    logic [CountW-1:0] point_count;
    logic              extrapolate_low;
    logic              extrapolate_high;
  } cfg_t;

  // Classified item handed from the front to the back.
  typedef struct packed {
    logic     valid;
    logic     is_query;
    in_item_t item;
  } front_t;

  typedef enum logic [3:0] {
    StIdle,
    StLowChk,
    StHighChk,
    StSearch,
    StHit,
    StSegA,
    StSegB,
    StCalc,
    StMul,
    StDiv,
    StFinish
  } back_state_e;

endpackage

@@ src/stli_front.sv @@
// ---------------------------------------------------------------------------
// Front end of the interpolator
// Accepts input beats into a two-entry queue and tags each as load or query.
// ---------------------------------------------------------------------------
module stli_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push,
  output logic               full,
  input  stli_pkg::in_item_t in_item_i,
  output stli_pkg::front_t   front_o,
  input  logic               take_i
);

  stli_pkg::in_item_t mem_q [2];
  logic               wr_ptr_q, rd_ptr_q;
  logic [1:0]         cnt_q;
  logic               do_push, do_pop;

  assign full    = (cnt_q == 2'd2);
  assign do_push = push && !full;
  assign do_pop  = take_i && (cnt_q != 2'd0);

  // Queue storage.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= in_item_i;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (do_push) wr_ptr_q <= ~wr_ptr_q;
      if (do_pop)  rd_ptr_q <= ~rd_ptr_q;
      cnt_q <= cnt_q + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

  // Classify the head item.
  always_comb begin
    front_o.valid    = (cnt_q != 2'd0);
    front_o.item     = mem_q[rd_ptr_q];
    front_o.is_query = (mem_q[rd_ptr_q].action == stli_pkg::ActQuery);
  end

endmodule

@@ src/stli_rslt_q.sv @@
// ---------------------------------------------------------------------------
// Result queue of the interpolator
// Two-entry queue that holds finished results until the consumer pops them.
// ---------------------------------------------------------------------------
module stli_rslt_q (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                wr_i,
  input  stli_pkg::out_item_t wr_item_i,
  output logic                full_o,
  output logic                empty,
  input  logic                pop,
  output stli_pkg::out_item_t out_item_o
);

  stli_pkg::out_item_t mem_q [2];
  logic                wr_ptr_q, rd_ptr_q;
  logic [1:0]          cnt_q;
  logic                do_wr, do_pop;

  assign full_o     = (cnt_q == 2'd2);
  assign empty      = (cnt_q == 2'd0);
  assign do_wr      = wr_i && !full_o;
  assign do_pop     = pop && !empty;
  assign out_item_o = mem_q[rd_ptr_q];

  // Queue storage.
  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wr_ptr_q] <= wr_item_i;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (do_wr)  wr_ptr_q <= ~wr_ptr_q;
      if (do_pop) rd_ptr_q <= ~rd_ptr_q;
      cnt_q <= cnt_q + {1'b0, do_wr} - {1'b0, do_pop};
    end
  end

endmodule

@@ src/stli_back.sv @@
// ---------------------------------------------------------------------------
// Back end of the interpolator
// Holds the breakpoint table, runs the binary search and the shift-add
// multiply and restoring divide that evaluate one segment.
// ---------------------------------------------------------------------------
`include "sorted_table_linear_interp_macros.svh"

module stli_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  stli_pkg::cfg_t      cfg_i,
  input  stli_pkg::front_t    front_i,
  output logic                take_o,
  input  logic                out_full_i,
  output logic                res_wr_o,
  output stli_pkg::out_item_t res_item_o
);

  localparam int AW = stli_pkg::AddrW;
  localparam int CW = stli_pkg::CountW;

  // Breakpoint table.
  logic signed [31:0] xmem [stli_pkg::TableDepth];
  logic signed [31:0] ymem [stli_pkg::TableDepth];
  logic signed [31:0] rdx_q, rdy_q;
  logic [AW-1:0]      raddr;
  logic               mem_we;

  stli_pkg::back_state_e state_q, state_d;
  logic signed [31:0] xi_q, xi_d, xa_q, xa_d, ya_q, ya_d, xb_q, xb_d, yb_q, yb_d;
  logic [CW-1:0]      n_q, n_d, lo_q, lo_d, cnt_q, cnt_d, step_q, step_d;
  logic [AW-1:0]      m_q, m_d;
  logic [32:0]        mdy_q, mdy_d, mdi_q, mdi_d, mdx_q, mdx_d, rem_q, rem_d;
  logic               neg_q, neg_d;
  logic [64:0]        prod_q, prod_d, quo_q, quo_d;

  // Scratch values for the combinational block.
  logic [CW-1:0]      n_lim, half, s_lo, s_cnt, s_m, s_clamp;
  logic signed [32:0] dy, dx, di;
  logic [33:0]        rem_t;
  logic signed [34:0] sum;

  assign mem_we = (state_q == stli_pkg::StIdle) && front_i.valid && !out_full_i
                  && !front_i.is_query;

  // Table write and registered read.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      xmem[front_i.item.entry_index] <= front_i.item.point_x;
      ymem[front_i.item.entry_index] <= front_i.item.point_y;
    end
    rdx_q <= xmem[raddr];
    rdy_q <= ymem[raddr];
  end

  // State and datapath registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= stli_pkg::StIdle;
      xi_q <= '0; xa_q <= '0; ya_q <= '0; xb_q <= '0; yb_q <= '0;
      n_q <= '0; lo_q <= '0; cnt_q <= '0; step_q <= '0; m_q <= '0;
      mdy_q <= '0; mdi_q <= '0; mdx_q <= '0; rem_q <= '0; neg_q <= 1'b0;
      prod_q <= '0; quo_q <= '0;
    end else begin
      state_q <= state_d;
      xi_q <= xi_d; xa_q <= xa_d; ya_q <= ya_d; xb_q <= xb_d; yb_q <= yb_d;
      n_q <= n_d; lo_q <= lo_d; cnt_q <= cnt_d; step_q <= step_d; m_q <= m_d;
      mdy_q <= mdy_d; mdi_q <= mdi_d; mdx_q <= mdx_d; rem_q <= rem_d;
      neg_q <= neg_d; prod_q <= prod_d; quo_q <= quo_d;
    end
  end

  // Sequencer: next state, read address and result.
  always_comb begin
    state_d = state_q;
    xi_d = xi_q; xa_d = xa_q; ya_d = ya_q; xb_d = xb_q; yb_d = yb_q;
    n_d = n_q; lo_d = lo_q; cnt_d = cnt_q; step_d = step_q; m_d = m_q;
    mdy_d = mdy_q; mdi_d = mdi_q; mdx_d = mdx_q; rem_d = rem_q; neg_d = neg_q;
    prod_d = prod_q; quo_d = quo_q;
    raddr      = '0;
    take_o     = 1'b0;
    res_wr_o   = 1'b0;
    res_item_o = '{result_y: ya_q, status: stli_pkg::StatusOk};
    n_lim = (cfg_i.point_count > CW'(stli_pkg::TableDepth))
            ? CW'(stli_pkg::TableDepth) : cfg_i.point_count;
    half    = cnt_q >> 1;
    s_lo    = lo_q;
    s_cnt   = half;
    s_m     = '0;
    s_clamp = '0;
    dy = 33'(yb_q) - 33'(ya_q);
    dx = 33'(xb_q) - 33'(xa_q);
    di = 33'(xi_q) - 33'(xa_q);
    rem_t = {rem_q, prod_q[64]};
    sum = 35'(ya_q);

    unique case (state_q)
      stli_pkg::StIdle: begin
        if (front_i.valid && !out_full_i) begin
          take_o = 1'b1;
          if (front_i.is_query) begin
            xi_d = front_i.item.query_x;
            n_d  = n_lim;
            if (n_lim < CW'(2)) begin
              res_wr_o   = 1'b1;
              res_item_o = '{result_y: '0, status: stli_pkg::StatusFew};
            end else begin
              raddr   = '0;
              state_d = stli_pkg::StLowChk;
            end
          end
        end
      end
      // Entry 0 is on the read port.
      stli_pkg::StLowChk: begin
        if (xi_q < rdx_q) begin
          if (cfg_i.extrapolate_low) begin
            xa_d = rdx_q; ya_d = rdy_q;
            raddr   = AW'(1);
            state_d = stli_pkg::StSegB;
          end else begin
            res_wr_o   = 1'b1;
            res_item_o = '{result_y: rdy_q, status: stli_pkg::StatusOk};
            state_d    = stli_pkg::StIdle;
          end
        end else begin
          raddr   = AW'(n_q - CW'(1));
          state_d = stli_pkg::StHighChk;
        end
      end
      // Last entry is on the read port.
      stli_pkg::StHighChk: begin
        if (xi_q > rdx_q) begin
          if (cfg_i.extrapolate_high) begin
            xb_d = rdx_q; yb_d = rdy_q;
            raddr   = AW'(n_q - CW'(2));
            state_d = stli_pkg::StSegA;
          end else begin
            res_wr_o   = 1'b1;
            res_item_o = '{result_y: rdy_q, status: stli_pkg::StatusOk};
            state_d    = stli_pkg::StIdle;
          end
        end else begin
          lo_d  = '0;
          cnt_d = n_q;
          m_d   = AW'(n_q >> 1);
          raddr = AW'(n_q >> 1);
          state_d = stli_pkg::StSearch;
        end
      end
      // One lower-bound step per read.
      stli_pkg::StSearch: begin
        if (rdx_q < xi_q) begin
          s_lo  = CW'(m_q) + CW'(1);
          s_cnt = cnt_q - half - CW'(1);
        end
        lo_d  = s_lo;
        cnt_d = s_cnt;
        if (s_cnt != '0) begin
          s_m   = s_lo + (s_cnt >> 1);
          m_d   = AW'(s_m);
          raddr = AW'(s_m);
        end else begin
          s_clamp = (s_lo >= n_q) ? n_q - CW'(1) : s_lo;
          lo_d    = s_clamp;
          raddr   = AW'(s_clamp);
          state_d = stli_pkg::StHit;
        end
      end
      stli_pkg::StHit: begin
        if (rdx_q == xi_q || lo_q == '0) begin
          res_wr_o   = 1'b1;
          res_item_o = '{result_y: rdy_q, status: stli_pkg::StatusOk};
          state_d    = stli_pkg::StIdle;
        end else begin
          xb_d = rdx_q; yb_d = rdy_q;
          raddr   = AW'(lo_q - CW'(1));
          state_d = stli_pkg::StSegA;
        end
      end
      stli_pkg::StSegA: begin
        xa_d = rdx_q; ya_d = rdy_q;
        state_d = stli_pkg::StCalc;
      end
      stli_pkg::StSegB: begin
        xb_d = rdx_q; yb_d = rdy_q;
        state_d = stli_pkg::StCalc;
      end
      // Segment set-up: signs and magnitudes.
      stli_pkg::StCalc: begin
        if (xa_q == xb_q) begin
          res_wr_o   = 1'b1;
          res_item_o = '{result_y: ya_q, status: stli_pkg::StatusOk};
          state_d    = stli_pkg::StIdle;
        end else begin
          neg_d  = (dy[32] ^ di[32]) ^ dx[32];
          mdy_d  = dy[32] ? 33'(-dy) : 33'(dy);
          mdi_d  = di[32] ? 33'(-di) : 33'(di);
          mdx_d  = dx[32] ? 33'(-dx) : 33'(dx);
          prod_d = '0;
          step_d = CW'(33);
          state_d = stli_pkg::StMul;
        end
      end
      // Shift-add multiply, one multiplier bit per cycle.
      stli_pkg::StMul: begin
        prod_d = {prod_q[63:0], 1'b0} + (mdi_q[32] ? {32'b0, mdy_q} : 65'b0);
        mdi_d  = {mdi_q[31:0], 1'b0};
        step_d = step_q - CW'(1);
        if (step_q == CW'(1)) begin
          rem_d   = '0;
          quo_d   = '0;
          step_d  = CW'(65);
          state_d = stli_pkg::StDiv;
        end
      end
      // Restoring divide, one quotient bit per cycle.
      stli_pkg::StDiv: begin
        prod_d = {prod_q[63:0], 1'b0};
        if (rem_t >= {1'b0, mdx_q}) begin
          rem_d = 33'(rem_t - {1'b0, mdx_q});
          quo_d = {quo_q[63:0], 1'b1};
        end else begin
          rem_d = rem_t[32:0];
          quo_d = {quo_q[63:0], 1'b0};
        end
        step_d = step_q - CW'(1);
        if (step_q == CW'(1)) begin
          state_d = stli_pkg::StFinish;
        end
      end
      // Add to y0 and saturate.
      stli_pkg::StFinish: begin
        sum = neg_q ? 35'(ya_q) - {2'b0, quo_q[32:0]} : 35'(ya_q) + {2'b0, quo_q[32:0]};
        res_wr_o = 1'b1;
        state_d  = stli_pkg::StIdle;
        if (quo_q[64:33] != '0) begin
          res_item_o.result_y = neg_q ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
          res_item_o.status   = stli_pkg::StatusSat;
        end else if (sum > 35'sh0_7FFF_FFFF) begin
          res_item_o.result_y = 32'sh7FFF_FFFF;
          res_item_o.status   = stli_pkg::StatusSat;
        end else if (sum < -35'sh0_8000_0000) begin
          res_item_o.result_y = 32'sh8000_0000;
          res_item_o.status   = stli_pkg::StatusSat;
        end else begin
          res_item_o.result_y = sum[31:0];
          res_item_o.status   = stli_pkg::StatusOk;
        end
      end
      default: state_d = stli_pkg::StIdle;
    endcase
  end

  // A result is only written when the queue has room.
  `STLI_ASSERT_NEVER(a_no_write_full, res_wr_o && out_full_i, "result written into full queue")
  // The divider never sees a zero divisor.
  `STLI_ASSERT_NEVER(a_div_nonzero, state_q == stli_pkg::StDiv && mdx_q == '0, "zero divisor")
  // Leaving idle always consumes an item from the front.
  `STLI_ASSERT(a_start_takes, (state_q == stli_pkg::StIdle && state_d != stli_pkg::StIdle) |-> take_o, "start without take")

endmodule

@@ src/sorted_table_linear_interp.sv @@
// Flow: a load and a query with under two points are handled in the idle state; an end clamp
// after the low or high check, an exact hit after the binary search, and an extrapolated or
// interpolated query after the segment reads, the 33-step multiply and the 65-step divide.
// Throughput: one item at a time in the back end; a two-entry queue on each side.
// Reset: asynchronous, active low; clears control and configuration, not the table.
// ---------------------------------------------------------------------------
// Piecewise-linear table interpolator
// Top level: configuration registers, front queue, back end and result queue.
// ---------------------------------------------------------------------------
module sorted_table_linear_interp (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push,
  output logic                full,
  input  stli_pkg::in_item_t  in_item_i,
  output logic                empty,
  input  logic                pop,
  output stli_pkg::out_item_t out_item_o,
  input  logic                cfg_we_i,
  input  logic [1:0]          cfg_idx_i,
  input  logic [6:0]          cfg_wdata_i
);

  stli_pkg::cfg_t      cfg_q;
  stli_pkg::front_t    front;
  stli_pkg::out_item_t res_item;
  logic                take, res_wr, out_full;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        stli_pkg::RegPointCount: cfg_q.point_count      <= cfg_wdata_i;
        stli_pkg::RegExtLow:     cfg_q.extrapolate_low  <= cfg_wdata_i[0];
        stli_pkg::RegExtHigh:    cfg_q.extrapolate_high <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  stli_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push      (push),
    .full      (full),
    .in_item_i (in_item_i),
    .front_o   (front),
    .take_i    (take)
  );

  stli_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .front_i    (front),
    .take_o     (take),
    .out_full_i (out_full),
    .res_wr_o   (res_wr),
    .res_item_o (res_item)
  );

  stli_rslt_q u_rslt_q (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_i       (res_wr),
    .wr_item_i  (res_item),
    .full_o     (out_full),
    .empty      (empty),
    .pop        (pop),
    .out_item_o (out_item_o)
  );

endmodule

@@ dv/tb_sorted_table_linear_interp.sv @@
// ---------------------------------------------------------------------------
// Testbench for the piecewise-linear table interpolator
// Loads breakpoint tables, sends queries under random pacing and stalls, and
// compares every result beat with an in-bench predictor of the interpolation.
// ---------------------------------------------------------------------------
module tb_sorted_table_linear_interp;
  timeunit 1ns;
  timeprecision 1ps;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic push = 1'b0;
  logic full;
  stli_pkg::in_item_t in_item_i = '0;
  logic empty;
  logic pop = 1'b0;
  stli_pkg::out_item_t out_item_o;
  logic cfg_we_i = 1'b0;
  logic [1:0] cfg_idx_i = stli_pkg::RegPointCount;
  logic [6:0] cfg_wdata_i = '0;

  sorted_table_linear_interp dut (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Predictor state: table copy and configuration.
  logic signed [31:0] tbl_x [stli_pkg::TableDepth];
  logic signed [31:0] tbl_y [stli_pkg::TableDepth];
  int unsigned cur_count;
  bit cur_ext_lo, cur_ext_hi;
  stli_pkg::out_item_t pending_results[$];
  int errors = 0;
  int burst_left = 0;

  // Segment evaluation with exact wide math, truncation and saturation.
  function automatic stli_pkg::out_item_t eval_segment(longint x0, longint x1, longint y0,
                                                       longint y1, longint xi);
    stli_pkg::out_item_t r;
    longint dy, dx, di, q, sum;
    bit neg;
    r.status = stli_pkg::StatusOk;
    if (x0 == x1) begin
      r.result_y = y0[31:0];
      return r;
    end
    dy = y1 - y0;
    dx = x1 - x0;
    di = xi - x0;
    neg = ((dy < 0) != (di < 0)) != (dx < 0);
    // The product fits in 66 bits; use unsigned 128-bit math.
    begin
      logic [127:0] p;
      p = 128'(dy < 0 ? -dy : dy) * 128'(di < 0 ? -di : di);
      p = p / 128'(dx < 0 ? -dx : dx);
      if (p > 128'h1_FFFF_FFFF) begin
        r.status = stli_pkg::StatusSat;
        r.result_y = neg ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
        return r;
      end
      q = longint'(p[63:0]);
    end
    sum = neg ? y0 - q : y0 + q;
    if (sum > 64'sd2147483647) begin
      r.status = stli_pkg::StatusSat;
      r.result_y = 32'sh7FFF_FFFF;
    end else if (sum < -64'sd2147483648) begin
      r.status = stli_pkg::StatusSat;
      r.result_y = 32'sh8000_0000;
    end else begin
      r.result_y = sum[31:0];
    end
    return r;
  endfunction

  // Expected result of one query against the current table and settings.
  function automatic stli_pkg::out_item_t interp_query(logic signed [31:0] qx);
    stli_pkg::out_item_t r;
    int unsigned n, lo, cnt, stp, m;
    longint xi;
    n = cur_count > stli_pkg::TableDepth ? stli_pkg::TableDepth : cur_count;
    xi = qx;
    r.status = stli_pkg::StatusOk;
    if (n < 2) begin
      r.result_y = '0;
      r.status = stli_pkg::StatusFew;
    end else if (xi < tbl_x[0]) begin
      if (cur_ext_lo) r = eval_segment(tbl_x[0], tbl_x[1], tbl_y[0], tbl_y[1], xi);
      else r.result_y = tbl_y[0];
    end else if (xi > tbl_x[n-1]) begin
      if (cur_ext_hi) begin
        r = eval_segment(tbl_x[n-2], tbl_x[n-1], tbl_y[n-2], tbl_y[n-1], xi);
      end else begin
        r.result_y = tbl_y[n-1];
      end
    end else begin
      lo = 0;
      cnt = n;
      while (cnt > 0) begin
        stp = cnt / 2;
        m = lo + stp;
        if (tbl_x[m] < xi) begin
          lo = m + 1;
          cnt -= stp + 1;
        end else begin
          cnt = stp;
        end
      end
      if (lo >= n) lo = n - 1;
      if (tbl_x[lo] == xi || lo == 0) r.result_y = tbl_y[lo];
      else r = eval_segment(tbl_x[lo-1], tbl_x[lo], tbl_y[lo-1], tbl_y[lo], xi);
    end
    return r;
  endfunction

  // Send one beat with bursty pacing; predict on acceptance.
  // Push stays high between beats of a burst and drops only for a gap.
  task automatic send_beat(stli_pkg::in_item_t it);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      if ($urandom_range(0, 3) != 0) begin
        push <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk_i);
      end
    end
    burst_left--;
    push <= 1'b1;
    in_item_i <= it;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    if (it.action == stli_pkg::ActLoad) begin
      tbl_x[it.entry_index] = it.point_x;
      tbl_y[it.entry_index] = it.point_y;
    end else begin
      pending_results.push_back(interp_query(it.query_x));
    end
  endtask

  task automatic load_entry(int idx, logic signed [31:0] x, logic signed [31:0] y);
    stli_pkg::in_item_t it;
    it = '0;
    it.action = stli_pkg::ActLoad;
    it.entry_index = idx[5:0];
    it.point_x = x;
    it.point_y = y;
    it.query_x = $urandom;
    send_beat(it);
  endtask

  task automatic query(logic signed [31:0] x);
    stli_pkg::in_item_t it;
    it.action = stli_pkg::ActQuery;
    it.entry_index = 6'($urandom);
    it.point_x = $urandom;
    it.point_y = $urandom;
    it.query_x = x;
    send_beat(it);
  endtask

  // Stop sending, drain all results, then give the back end time to finish any load.
  task automatic wait_idle();
    push <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  // One register write; the write enable is dropped by the caller.
  task automatic write_reg(logic [1:0] idx, int unsigned val);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= val[6:0];
    @(posedge clk_i);
    case (idx)
      stli_pkg::RegPointCount: cur_count = val & 7'h7F;
      stli_pkg::RegExtLow: cur_ext_lo = val[0];
      default: cur_ext_hi = val[0];
    endcase
  endtask

  task automatic configure(int unsigned cnt, bit lo, bit hi);
    wait_idle();
    write_reg(stli_pkg::RegPointCount, cnt);
    write_reg(stli_pkg::RegExtLow, int'(lo));
    write_reg(stli_pkg::RegExtHigh, int'(hi));
    cfg_we_i <= 1'b0;
  endtask

  // Fill entries 0..n-1 with ascending x (duplicates allowed) and random y.
  task automatic load_sorted_table(int n, int unsigned span);
    longint x;
    x = -longint'($urandom_range(0, 32'h7000_0000));
    for (int i = 0; i < n; i++) begin
      if (i > 0 && $urandom_range(0, 9) != 0) x += $urandom_range(1, span);
      if (x > 64'sd2147483647) x = 64'sd2147483647;
      load_entry(i, x[31:0], $urandom);
    end
  endtask

  function automatic logic signed [31:0] pick_query(int n);
    int k;
    k = $urandom_range(0, n - 1);
    case ($urandom_range(0, 4))
      0: return tbl_x[k];
      1: return tbl_x[k] + $signed($urandom_range(0, 64)) - 32;
      2: return $urandom;
      default: return tbl_x[k] + $urandom_range(0, 16'hFFFF);
    endcase
  endfunction

  // Directed: too few points, exact hits, clamps, extrapolation, saturation.
  task automatic test_directed();
    configure(0, 0, 0);
    query(32'sh0);
    configure(1, 0, 0);
    load_entry(0, 32'sh8000_0000, 32'sh7FFF_FFFF);
    query(32'sh7FFF_FFFF);
    load_entry(1, 32'sh0, 32'sh8000_0000);
    load_entry(2, 32'sh0, 32'sh1234);
    load_entry(3, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
    configure(4, 0, 0);
    query(32'sh8000_0000);
    query(32'sh0);
    query(32'sh7FFF_FFFF);
    query(32'sh4000_0000);
    query(-32'sd1);
    // Steep segment to force saturation on extrapolation.
    load_entry(0, 32'sh0001_0000, 32'sh0);
    load_entry(1, 32'sh0001_0001, 32'sh7FFF_FFFF);
    load_entry(2, 32'sh0002_0000, 32'sh8000_0000);
    load_entry(3, 32'sh0002_0001, 32'sh7FFF_FFFF);
    configure(4, 1, 1);
    query(32'sh8000_0000);
    query(32'sh7FFF_FFFF);
    query(32'sh0001_8000);
    query(32'sh0000_0000);
    configure(127, 1, 0);
    for (int i = 4; i < stli_pkg::TableDepth; i++) load_entry(i, 32'sh7FFF_FFFF, i);
    query(32'sh7FFF_FFFF);
    query(32'sh0002_0000);
  endtask

  // Random phases: a sorted table, a few settings, mostly queries.
  task automatic test_random(int phases);
    int n;
    for (int p = 0; p < phases; p++) begin
      n = ($urandom_range(0, 9) == 0) ? stli_pkg::TableDepth : $urandom_range(2, 10);
      wait_idle();
      load_sorted_table(n, ($urandom_range(0, 1) != 0) ? 32'h0100_0000 : 32'h0000_0400);
      configure(($urandom_range(0, 9) == 0) ? $urandom_range(65, 127) :
                $urandom_range(2, n), 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
      for (int q = 0; q < 30; q++) query(pick_query(n));
    end
  endtask

  // Unsorted table: search still runs, answer follows the same rules.
  task automatic test_unsorted();
    configure(0, 0, 0);
    for (int i = 0; i < 8; i++) load_entry(i, $urandom, $urandom);
    configure(8, 1, 1);
    for (int q = 0; q < 40; q++) query(pick_query(8));
    // A single-point count on a used table gives the too-few-points status.
    configure(1, 0, 0);
    query($urandom);
  endtask

  // Result checker and receiver stall pattern.
  always @(posedge clk_i) begin
    stli_pkg::out_item_t want;
    if (rst_ni && pop && !empty) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result beat %h", $realtime, out_item_o);
        errors++;
      end else begin
        want = pending_results.pop_front();
        if (out_item_o.result_y !== want.result_y) begin
          $display("%0t: result_y expected %h actual %h", $realtime, want.result_y,
                   out_item_o.result_y);
          errors++;
        end
        if (out_item_o.status !== want.status) begin
          $display("%0t: status expected %0d actual %0d", $realtime, want.status,
                   out_item_o.status);
          errors++;
        end
      end
    end
    pop <= ($time / 2000) % 3 == 0 ? 1'b1 : ($urandom_range(0, 3) != 0);
  end

  initial begin
    for (int i = 0; i < stli_pkg::TableDepth; i++) begin
      tbl_x[i] = '0;
      tbl_y[i] = '0;
    end
    cur_count = 0;
    cur_ext_lo = 0;
    cur_ext_hi = 0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_unsorted();
    test_random(50);
    wait_idle();
    repeat (200) @(posedge clk_i);
    if (errors == 0 && pending_results.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("status: fail");
    $finish;
  end

endmodule

@@ sorted_table_linear_interp.f @@
+incdir+src
src/stli_pkg.sv
src/stli_front.sv
src/stli_rslt_q.sv
src/stli_back.sv
src/sorted_table_linear_interp.sv
dv/tb_sorted_table_linear_interp.sv
